// ----- src/uhp_pkg.sv -----
package uhp_pkg;

   localparam int unsigned LINE_NUMBER_BITS_DEF = 32;
   localparam int unsigned HUNK_COUNT_BITS_DEF  = 16;

   // result kinds
   localparam logic [2:0] KIND_LOCATION = 3'd0;
   localparam logic [2:0] KIND_CONTENT  = 3'd1;
   localparam logic [2:0] KIND_LINE_END = 3'd2;
   localparam logic [2:0] KIND_FINISHED = 3'd3;
   localparam logic [2:0] KIND_ERROR    = 3'd4;

   // line operations
   localparam logic [1:0] OP_CONTEXT  = 2'd0;
   localparam logic [1:0] OP_ADDITION = 2'd1;
   localparam logic [1:0] OP_REMOVAL  = 2'd2;

   // error codes
   localparam logic [2:0] ERR_NONE       = 3'd0;
   localparam logic [2:0] ERR_EMPTY_LINE = 3'd1;
   localparam logic [2:0] ERR_BAD_OP     = 3'd2;
   localparam logic [2:0] ERR_NEW_OVER   = 3'd3;
   localparam logic [2:0] ERR_OLD_OVER   = 3'd4;

   // request actions
   localparam logic ACT_BYTE = 1'b0;
   localparam logic ACT_END  = 1'b1;

   // parser phases
   localparam logic [2:0] PH_PREAMBLE = 3'd0;
   localparam logic [2:0] PH_HEADER   = 3'd1;
   localparam logic [2:0] PH_HDR_TAIL = 3'd2;
   localparam logic [2:0] PH_CONTENT  = 3'd3;
   localparam logic [2:0] PH_BETWEEN  = 3'd4;
   localparam logic [2:0] PH_DONE     = 3'd5;

   // positions within "-a,b +c,d @@"
   localparam logic [3:0] HP_DASH      = 4'd0;
   localparam logic [3:0] HP_OLD_START = 4'd1;
   localparam logic [3:0] HP_OLD_COUNT = 4'd2;
   localparam logic [3:0] HP_SPACE_1   = 4'd3;
   localparam logic [3:0] HP_PLUS      = 4'd4;
   localparam logic [3:0] HP_NEW_START = 4'd5;
   localparam logic [3:0] HP_NEW_COUNT = 4'd6;
   localparam logic [3:0] HP_SPACE_2   = 4'd7;
   localparam logic [3:0] HP_AT_1      = 4'd8;
   localparam logic [3:0] HP_AT_2      = 4'd9;

   // characters
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_AT    = 8'h40;

   typedef struct packed {
      logic       emit;
      logic [2:0] kind;
      logic [1:0] line_op;
      logic [7:0] content_byte;
      logic [2:0] error_code;
   } rsp_ctl_type;

endpackage

// ----- src/uhp_if.sv -----
interface uhp_req_if import uhp_pkg::*;;
   logic       valid;
   logic       ready;
   logic       action;
   logic [7:0] text_byte;

   modport source (output valid, output action, output text_byte, input ready);
   modport sink   (input valid, input action, input text_byte, output ready);
endinterface

interface uhp_rsp_if import uhp_pkg::*; #(
   parameter int unsigned LINE_NUMBER_BITS = LINE_NUMBER_BITS_DEF,
   parameter int unsigned HUNK_COUNT_BITS  = HUNK_COUNT_BITS_DEF
);
   logic                        valid;
   logic                        ready;
   logic [2:0]                  kind;
   logic [1:0]                  line_op;
   logic [7:0]                  content_byte;
   logic [LINE_NUMBER_BITS-1:0] old_start;
   logic [LINE_NUMBER_BITS-1:0] old_count;
   logic [LINE_NUMBER_BITS-1:0] new_start;
   logic [LINE_NUMBER_BITS-1:0] new_count;
   logic [2:0]                  error_code;
   logic [HUNK_COUNT_BITS-1:0]  hunks_seen;

   modport source (output valid, output kind, output line_op, output content_byte,
                   output old_start, output old_count, output new_start,
                   output new_count, output error_code, output hunks_seen,
                   input ready);
   modport sink   (input valid, input kind, input line_op, input content_byte,
                   input old_start, input old_count, input new_start,
                   input new_count, input error_code, input hunks_seen,
                   output ready);
endinterface

// ----- src/unified_diff_hunk_parser.sv -----
// Path: a request's result, if it has one, goes through the input register, then the result
// register, to rsp; a stalled rsp holds it. Throughput: one request per cycle while rsp is not
// stalled; the parser step is a single pass between the registers.
// Reset: synchronous, active high; clears the parser state and both valid flags.
// After a finished or error result every further request is taken and yields nothing.
module unified_diff_hunk_parser import uhp_pkg::*; #(
   parameter int unsigned LINE_NUMBER_BITS = LINE_NUMBER_BITS_DEF,
   parameter int unsigned HUNK_COUNT_BITS  = HUNK_COUNT_BITS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   uhp_req_if.sink   req,
   uhp_rsp_if.source rsp
);
   localparam int unsigned LB = LINE_NUMBER_BITS;
   localparam int unsigned HB = HUNK_COUNT_BITS;

   logic          in_valid_ff, in_valid_in;
   logic          in_action_ff;
   logic [7:0]    in_byte_ff;
   logic          out_valid_ff, out_valid_in;
   rsp_ctl_type   out_ctl_ff;
   logic [LB-1:0] out_old_start_ff, out_old_count_ff, out_new_start_ff, out_new_count_ff;
   logic [HB-1:0] out_tally_ff;

   logic          advance;
   logic          take_req;
   rsp_ctl_type   res;
   logic [LB-1:0] loc_old_start, loc_old_count, loc_new_start, loc_new_count;
   logic [HB-1:0] tally;

   // step the parser once the result register can take whatever it produces
   assign advance  = in_valid_ff && (!out_valid_ff || rsp.ready);
   assign req.ready = !in_valid_ff || advance;
   assign take_req = req.valid && req.ready;

   assign in_valid_in  = take_req || (in_valid_ff && !advance);
   assign out_valid_in = (advance && res.emit) || (out_valid_ff && !rsp.ready);

   uhp_core #(
      .LINE_NUMBER_BITS (LB),
      .HUNK_COUNT_BITS  (HB)
   ) u_core (
      .clock         (clock),
      .reset         (reset),
      .advance       (advance),
      .action        (in_action_ff),
      .text_byte     (in_byte_ff),
      .res           (res),
      .loc_old_start (loc_old_start),
      .loc_old_count (loc_old_count),
      .loc_new_start (loc_new_start),
      .loc_new_count (loc_new_count),
      .hunks_seen    (tally)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take_req) begin
         in_action_ff <= req.action;
         in_byte_ff   <= req.text_byte;
      end
      if (advance && res.emit) begin
         out_ctl_ff       <= res;
         out_old_start_ff <= loc_old_start;
         out_old_count_ff <= loc_old_count;
         out_new_start_ff <= loc_new_start;
         out_new_count_ff <= loc_new_count;
         out_tally_ff     <= tally;
      end
   end

   assign rsp.valid        = out_valid_ff;
   assign rsp.kind         = out_ctl_ff.kind;
   assign rsp.line_op      = out_ctl_ff.line_op;
   assign rsp.content_byte = out_ctl_ff.content_byte;
   assign rsp.error_code   = out_ctl_ff.error_code;
   assign rsp.old_start    = out_old_start_ff;
   assign rsp.old_count    = out_old_count_ff;
   assign rsp.new_start    = out_new_start_ff;
   assign rsp.new_count    = out_new_count_ff;
   assign rsp.hunks_seen   = out_tally_ff;
endmodule

// ----- src/uhp_num.sv -----
module uhp_num import uhp_pkg::*; #(
   parameter int unsigned LINE_NUMBER_BITS = LINE_NUMBER_BITS_DEF
) (
   input  logic [LINE_NUMBER_BITS-1:0] acc,
   input  logic [3:0]                  digit,
   output logic [LINE_NUMBER_BITS-1:0] acc_next,
   output logic                        overflow
);
   localparam int unsigned WIDE_BITS = LINE_NUMBER_BITS + 4;

   logic [WIDE_BITS-1:0] acc_wide;
   logic [WIDE_BITS-1:0] sum;

   // acc*10 + digit, as two shifts and two adds; any carry into the top bits overflows
   assign acc_wide = {4'b0000, acc};
   assign sum      = (acc_wide << 3) + (acc_wide << 1) + {{LINE_NUMBER_BITS{1'b0}}, digit};
   assign acc_next = sum[LINE_NUMBER_BITS-1:0];
   assign overflow = |sum[WIDE_BITS-1:LINE_NUMBER_BITS];
endmodule

// ----- src/uhp_core.sv -----
module uhp_core import uhp_pkg::*; #(
   parameter int unsigned LINE_NUMBER_BITS = LINE_NUMBER_BITS_DEF,
   parameter int unsigned HUNK_COUNT_BITS  = HUNK_COUNT_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        advance,
   input  logic                        action,
   input  logic [7:0]                  text_byte,
   output rsp_ctl_type                 res,
   output logic [LINE_NUMBER_BITS-1:0] loc_old_start,
   output logic [LINE_NUMBER_BITS-1:0] loc_old_count,
   output logic [LINE_NUMBER_BITS-1:0] loc_new_start,
   output logic [LINE_NUMBER_BITS-1:0] loc_new_count,
   output logic [HUNK_COUNT_BITS-1:0]  hunks_seen
);
   localparam int unsigned LB = LINE_NUMBER_BITS;
   localparam int unsigned HB = HUNK_COUNT_BITS;

   logic [2:0]    phase_ff, phase_in;
   logic [3:0]    hdr_pos_ff, hdr_pos_in;
   logic [1:0]    prefix_ff, prefix_in;
   logic          line_start_ff, line_start_in;
   logic [LB-1:0] acc_ff, acc_in;
   logic          digit_seen_ff, digit_seen_in;
   logic [LB-1:0] old_start_ff, old_start_in;
   logic [LB-1:0] old_count_ff, old_count_in;
   logic [LB-1:0] new_start_ff, new_start_in;
   logic [LB-1:0] new_count_ff, new_count_in;
   logic [LB-1:0] old_rem_ff, old_rem_in;
   logic [LB-1:0] new_rem_ff, new_rem_in;
   logic [1:0]    op_ff, op_in;
   logic          pending_cr_ff, pending_cr_in;
   logic [HB-1:0] tally_ff, tally_in;

   logic [LB-1:0] acc_next;
   logic          acc_overflow;

   logic          eol, is_digit, skip_lf, count_hunk, do_finish, do_fail;
   logic          lit_check, lit_bad;
   logic [2:0]    fail_code;
   logic [3:0]    lit_pos;
   logic [7:0]    want;
   logic [7:0]    mark;
   logic [1:0]    op_sym;
   logic          op_ok;
   logic          rems_zero;

   uhp_num #(.LINE_NUMBER_BITS(LB)) u_num (
      .acc      (acc_ff),
      .digit    (text_byte[3:0]),
      .acc_next (acc_next),
      .overflow (acc_overflow)
   );

   assign eol       = (text_byte == CH_LF) || (text_byte == CH_CR);
   assign is_digit  = (text_byte >= CH_ZERO) && (text_byte <= CH_NINE);
   assign skip_lf   = pending_cr_ff && (text_byte == CH_LF);
   assign mark      = (prefix_ff == 2'd2) ? CH_SPACE : CH_AT;
   assign rems_zero = (old_rem_ff == '0) && (new_rem_ff == '0);

   always_comb begin
      op_sym = OP_CONTEXT;
      op_ok  = 1'b1;
      case (text_byte)
         CH_SPACE: op_sym = OP_CONTEXT;
         CH_PLUS:  op_sym = OP_ADDITION;
         CH_MINUS: op_sym = OP_REMOVAL;
         default:  op_ok  = 1'b0;
      endcase
   end

   always_comb begin
      phase_in      = phase_ff;
      hdr_pos_in    = hdr_pos_ff;
      prefix_in     = prefix_ff;
      line_start_in = line_start_ff;
      acc_in        = acc_ff;
      digit_seen_in = digit_seen_ff;
      old_start_in  = old_start_ff;
      old_count_in  = old_count_ff;
      new_start_in  = new_start_ff;
      new_count_in  = new_count_ff;
      old_rem_in    = old_rem_ff;
      new_rem_in    = new_rem_ff;
      op_in         = op_ff;
      pending_cr_in = pending_cr_ff;
      count_hunk    = 1'b0;
      do_finish     = 1'b0;
      do_fail       = 1'b0;
      fail_code     = ERR_NONE;
      lit_check     = 1'b0;
      lit_bad       = 1'b0;
      lit_pos       = hdr_pos_ff;
      want          = CH_AT;
      res           = '0;

      if (phase_ff != PH_DONE) begin
         if (action == ACT_END) begin
            pending_cr_in = 1'b0;
            if ((phase_ff == PH_HDR_TAIL) || (phase_ff == PH_CONTENT)) begin
               if (!((phase_ff == PH_CONTENT) && line_start_ff) && rems_zero) begin
                  count_hunk = 1'b1;
                  do_finish  = 1'b1;
               end else begin
                  do_fail   = 1'b1;
                  fail_code = ERR_EMPTY_LINE;
               end
            end else begin
               do_finish = 1'b1;
            end
         end else begin
            pending_cr_in = (text_byte == CH_CR);
            if (!skip_lf) begin
               case (phase_ff)
                  PH_PREAMBLE, PH_BETWEEN: begin
                     if (line_start_ff) begin
                        if (prefix_ff != 2'd3 && text_byte == mark) begin
                           if (prefix_ff == 2'd2) begin
                              prefix_in     = 2'd0;
                              line_start_in = 1'b0;
                              hdr_pos_in    = HP_DASH;
                              acc_in        = '0;
                              digit_seen_in = 1'b0;
                              phase_in      = PH_HEADER;
                           end else begin
                              prefix_in = prefix_ff + 2'd1;
                           end
                        end else begin
                           prefix_in = 2'd0;
                           if (phase_ff == PH_BETWEEN) begin
                              do_finish = 1'b1;
                           end else begin
                              line_start_in = eol;
                           end
                        end
                     end else if (eol) begin
                        line_start_in = 1'b1;
                     end
                  end
                  PH_HEADER: begin
                     if (hdr_pos_ff == HP_OLD_START || hdr_pos_ff == HP_OLD_COUNT ||
                         hdr_pos_ff == HP_NEW_START || hdr_pos_ff == HP_NEW_COUNT) begin
                        if (is_digit) begin
                           if (acc_overflow) begin
                              do_finish = 1'b1;
                           end else begin
                              acc_in        = acc_next;
                              digit_seen_in = 1'b1;
                           end
                        end else if (!digit_seen_ff) begin
                           do_finish = 1'b1;
                        end else begin
                           case (hdr_pos_ff)
                              HP_OLD_START: old_start_in = acc_ff;
                              HP_OLD_COUNT: old_count_in = acc_ff;
                              HP_NEW_START: new_start_in = acc_ff;
                              default:      new_count_in = acc_ff;
                           endcase
                           acc_in        = '0;
                           digit_seen_in = 1'b0;
                           if ((hdr_pos_ff == HP_OLD_START || hdr_pos_ff == HP_NEW_START) &&
                               text_byte == CH_COMMA) begin
                              hdr_pos_in = hdr_pos_ff + 4'd1;
                           end else begin
                              // missing count defaults to one
                              if (hdr_pos_ff == HP_OLD_START) begin
                                 old_count_in = {{(LB-1){1'b0}}, 1'b1};
                              end
                              if (hdr_pos_ff == HP_NEW_START) begin
                                 new_count_in = {{(LB-1){1'b0}}, 1'b1};
                              end
                              lit_pos   = (hdr_pos_ff <= HP_OLD_COUNT) ? HP_SPACE_1 : HP_SPACE_2;
                              lit_check = 1'b1;
                           end
                        end
                     end else begin
                        lit_check = 1'b1;
                     end
                     if (lit_check) begin
                        case (lit_pos)
                           HP_DASH:    want = CH_MINUS;
                           HP_SPACE_1: want = CH_SPACE;
                           HP_PLUS:    want = CH_PLUS;
                           HP_SPACE_2: want = CH_SPACE;
                           HP_AT_1:    want = CH_AT;
                           HP_AT_2:    want = CH_AT;
                           default:    lit_bad = 1'b1;
                        endcase
                        if (lit_bad || text_byte != want) begin
                           do_finish = 1'b1;
                        end else if (lit_pos == HP_AT_2) begin
                           old_rem_in    = old_count_ff;
                           new_rem_in    = new_count_ff;
                           hdr_pos_in    = HP_DASH;
                           line_start_in = 1'b0;
                           phase_in      = PH_HDR_TAIL;
                           res.emit      = 1'b1;
                           res.kind      = KIND_LOCATION;
                        end else begin
                           hdr_pos_in = lit_pos + 4'd1;
                        end
                     end
                  end
                  PH_HDR_TAIL: begin
                     if (eol) begin
                        line_start_in = 1'b1;
                        if (rems_zero) begin
                           count_hunk = 1'b1;
                           prefix_in  = 2'd0;
                           phase_in   = PH_BETWEEN;
                        end else begin
                           phase_in = PH_CONTENT;
                        end
                     end
                  end
                  PH_CONTENT: begin
                     if (line_start_ff) begin
                        if (eol) begin
                           do_fail   = 1'b1;
                           fail_code = ERR_EMPTY_LINE;
                        end else if (!op_ok) begin
                           do_fail   = 1'b1;
                           fail_code = ERR_BAD_OP;
                        end else if (op_sym != OP_REMOVAL && new_rem_ff == '0) begin
                           do_fail   = 1'b1;
                           fail_code = ERR_NEW_OVER;
                        end else if (op_sym != OP_ADDITION && old_rem_ff == '0) begin
                           do_fail   = 1'b1;
                           fail_code = ERR_OLD_OVER;
                        end else begin
                           if (op_sym != OP_REMOVAL) begin
                              new_rem_in = new_rem_ff - {{(LB-1){1'b0}}, 1'b1};
                           end
                           if (op_sym != OP_ADDITION) begin
                              old_rem_in = old_rem_ff - {{(LB-1){1'b0}}, 1'b1};
                           end
                           op_in         = op_sym;
                           line_start_in = 1'b0;
                        end
                     end else if (eol) begin
                        line_start_in = 1'b1;
                        if (rems_zero) begin
                           count_hunk = 1'b1;
                           prefix_in  = 2'd0;
                           phase_in   = PH_BETWEEN;
                        end
                        res.emit    = 1'b1;
                        res.kind    = KIND_LINE_END;
                        res.line_op = op_ff;
                     end else begin
                        res.emit         = 1'b1;
                        res.kind         = KIND_CONTENT;
                        res.line_op      = op_ff;
                        res.content_byte = text_byte;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         if (do_finish) begin
            phase_in = PH_DONE;
            res      = '0;
            res.emit = 1'b1;
            res.kind = KIND_FINISHED;
         end
         if (do_fail) begin
            phase_in       = PH_DONE;
            res            = '0;
            res.emit       = 1'b1;
            res.kind       = KIND_ERROR;
            res.error_code = fail_code;
         end
      end
   end

   // saturate the hunk tally
   assign tally_in   = (count_hunk && (tally_ff != {HB{1'b1}})) ? tally_ff + {{(HB-1){1'b0}}, 1'b1}
                                                                : tally_ff;
   assign hunks_seen = tally_in;

   assign loc_old_start = (res.kind == KIND_LOCATION) ? old_start_ff : '0;
   assign loc_old_count = (res.kind == KIND_LOCATION) ? old_count_ff : '0;
   assign loc_new_start = (res.kind == KIND_LOCATION) ? new_start_ff : '0;
   assign loc_new_count = (res.kind == KIND_LOCATION) ? new_count_ff : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_PREAMBLE;
         hdr_pos_ff    <= HP_DASH;
         prefix_ff     <= 2'd0;
         line_start_ff <= 1'b1;
         acc_ff        <= '0;
         digit_seen_ff <= 1'b0;
         old_start_ff  <= '0;
         old_count_ff  <= '0;
         new_start_ff  <= '0;
         new_count_ff  <= '0;
         old_rem_ff    <= '0;
         new_rem_ff    <= '0;
         op_ff         <= OP_CONTEXT;
         pending_cr_ff <= 1'b0;
         tally_ff      <= '0;
      end else if (advance) begin
         phase_ff      <= phase_in;
         hdr_pos_ff    <= hdr_pos_in;
         prefix_ff     <= prefix_in;
         line_start_ff <= line_start_in;
         acc_ff        <= acc_in;
         digit_seen_ff <= digit_seen_in;
         old_start_ff  <= old_start_in;
         old_count_ff  <= old_count_in;
         new_start_ff  <= new_start_in;
         new_count_ff  <= new_count_in;
         old_rem_ff    <= old_rem_in;
         new_rem_ff    <= new_rem_in;
         op_ff         <= op_in;
         pending_cr_ff <= pending_cr_in;
         tally_ff      <= tally_in;
      end
   end
endmodule

// ----- src/uhp_checker.sv -----
module uhp_checker import uhp_pkg::*; #(
   parameter int unsigned LINE_NUMBER_BITS = LINE_NUMBER_BITS_DEF
) (
   input logic                        clock,
   input logic                        reset,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [2:0]                  rsp_kind,
   input logic [1:0]                  rsp_line_op,
   input logic [2:0]                  rsp_error_code,
   input logic [LINE_NUMBER_BITS-1:0] rsp_old_start,
   input logic [LINE_NUMBER_BITS-1:0] rsp_old_count,
   input logic [LINE_NUMBER_BITS-1:0] rsp_new_start,
   input logic [LINE_NUMBER_BITS-1:0] rsp_new_count
);
   logic done_ff, done_in;

   // note that a finished or error result has been delivered
   assign done_in = done_ff || (rsp_valid && rsp_ready &&
                    (rsp_kind == KIND_FINISHED || rsp_kind == KIND_ERROR));

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= done_in;
      end
   end

   a_silent_after_end: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !rsp_valid)
      else $error("result shown after parsing ended");

   a_location_only: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind != KIND_LOCATION) |->
      (rsp_old_start == '0 && rsp_old_count == '0 &&
       rsp_new_start == '0 && rsp_new_count == '0))
      else $error("hunk range shown on a non-location result");

   a_error_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_kind == KIND_ERROR) == (rsp_error_code != ERR_NONE)) &&
                    ((rsp_kind == KIND_CONTENT || rsp_kind == KIND_LINE_END) ||
                     rsp_line_op == OP_CONTEXT))
      else $error("error code or operation disagrees with kind");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_kind)))
      else $error("stalled result dropped or changed");
endmodule

bind unified_diff_hunk_parser uhp_checker #(
   .LINE_NUMBER_BITS (LINE_NUMBER_BITS)
) u_uhp_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp.valid),
   .rsp_ready      (rsp.ready),
   .rsp_kind       (rsp.kind),
   .rsp_line_op    (rsp.line_op),
   .rsp_error_code (rsp.error_code),
   .rsp_old_start  (rsp.old_start),
   .rsp_old_count  (rsp.old_count),
   .rsp_new_start  (rsp.new_start),
   .rsp_new_count  (rsp.new_count)
);
